>>> rtl/core/sltc_pkg.sv
package sltc_pkg;

  localparam int ELEM_W        = 4;
  localparam int COUNT_W       = 5;
  localparam int REQ_W         = 2;
  localparam int DEF_MAX_ELEMS = 16;

  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CHECK = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ELEM_W-1:0] row_elem;
    logic [ELEM_W-1:0] col_elem;
    logic [ELEM_W-1:0] value_elem;
  } req_t;

  typedef struct packed {
    logic [ELEM_W-1:0] read_value;
    logic              bad_element;
    logic              assoc_ok;
    logic              comm_ok;
    logic              idem_ok;
    logic              valid_ok;
  } result_t;

endpackage

>>> rtl/core/sltc_table.sv
module sltc_table #(
  parameter int AW = 8
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [sltc_pkg::ELEM_W-1:0] wdata,
  input  logic [AW-1:0]             a_addr,
  input  logic [AW-1:0]             b_addr,
  output logic [sltc_pkg::ELEM_W-1:0] a_q,
  output logic [sltc_pkg::ELEM_W-1:0] b_q
);
  import sltc_pkg::*;

  logic [ELEM_W-1:0] mem [(1<<AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    a_q <= mem[a_addr];
    b_q <= mem[b_addr];
  end

endmodule

>>> rtl/core/sltc_engine.sv
module sltc_engine #(
  parameter int MAX_ELEMS = sltc_pkg::DEF_MAX_ELEMS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  sltc_pkg::req_t               req,
  input  logic [sltc_pkg::COUNT_W-1:0] n_eff,
  output logic                         out_valid,
  output sltc_pkg::result_t            res
);
  import sltc_pkg::*;

  // only indices below 2^ELEM_W can ever be written; larger ones keep reset values
  localparam int EDIM = (MAX_ELEMS < (1 << ELEM_W)) ? MAX_ELEMS : (1 << ELEM_W);
  localparam int IW   = $clog2(EDIM);
  localparam int AW   = 2 * IW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_AXY   = 3'd2;
  localparam logic [2:0] ST_AXYW  = 3'd3;
  localparam logic [2:0] ST_AZ0   = 3'd4;
  localparam logic [2:0] ST_AZ1   = 3'd5;
  localparam logic [2:0] ST_CMP   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      clr_cnt_r;
  logic [COUNT_W-1:0] n_r, x_r, y_r, z_r;
  logic [ELEM_W-1:0]  xy_r, right_r, xd_r;
  logic               cmp_pend_r, cpend_r, diag_r;
  logic               assoc_r, comm_r, idem_r;

  logic               ov_r, bad_r, rq_r, fa_r, fc_r, fi_r, fv_r;

  logic [COUNT_W-1:0] a_row, a_col, b_row, b_col;
  logic               a_hit, b_hit, a_hit_r, b_hit_r;
  logic [ELEM_W-1:0]  a_const, b_const, a_const_r, b_const_r;
  logic [ELEM_W-1:0]  a_q, b_q, a_data, b_data;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [ELEM_W-1:0]  wdata;

  logic               accept, req_bad, last_x, last_y, last_z;
  logic               comm_fin, idem_fin;
  logic [COUNT_W-1:0] req_row, req_col, req_val;
  logic [IW-1:0]      clr_row, clr_col;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign req_row = COUNT_W'(req.row_elem);
  assign req_col = COUNT_W'(req.col_elem);
  assign req_val = COUNT_W'(req.value_elem);

  always_comb begin
    req_bad = 1'b0;
    case (req.req_type)
      REQ_WRITE: req_bad = (req_row >= n_eff) || (req_col >= n_eff) || (req_val >= n_eff);
      REQ_QUERY: req_bad = (req_row >= n_eff) || (req_col >= n_eff);
      default:   req_bad = 1'b0;
    endcase
  end

  assign last_x = (x_r == n_r - COUNT_W'(1));
  assign last_y = (y_r == n_r - COUNT_W'(1));
  assign last_z = (z_r == n_r - COUNT_W'(1));

  // read address selection for both ports
  always_comb begin
    a_row = req_row;
    a_col = req_col;
    b_row = req_row;
    b_col = req_col;
    case (state_r)
      ST_AXY: begin
        a_row = x_r;
        a_col = y_r;
      end
      ST_AZ0: begin
        a_row = y_r;
        a_col = z_r;
        b_row = COUNT_W'(xy_r);
        b_col = z_r;
      end
      ST_AZ1: begin
        a_row = x_r;
        a_col = COUNT_W'(a_data);
      end
      ST_CMP: begin
        a_row = x_r;
        a_col = y_r;
        b_row = y_r;
        b_col = x_r;
      end
      default: ;
    endcase
  end

  // entries outside the stored square hold their reset values
  assign a_hit   = (int'(a_row) < EDIM) && (int'(a_col) < EDIM);
  assign b_hit   = (int'(b_row) < EDIM) && (int'(b_col) < EDIM);
  assign a_const = ((int'(a_row) < MAX_ELEMS) && (a_row == a_col)) ? a_row[ELEM_W-1:0] : '0;
  assign b_const = ((int'(b_row) < MAX_ELEMS) && (b_row == b_col)) ? b_row[ELEM_W-1:0] : '0;

  assign a_data = a_hit_r ? a_q : a_const_r;
  assign b_data = b_hit_r ? b_q : b_const_r;

  assign clr_row = clr_cnt_r[AW-1:IW];
  assign clr_col = clr_cnt_r[IW-1:0];

  always_comb begin
    if (state_r == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = (clr_row == clr_col) ? ELEM_W'(clr_row) : '0;
    end else begin
      we    = accept && (req.req_type == REQ_WRITE) && !req_bad;
      waddr = {req_row[IW-1:0], req_col[IW-1:0]};
      wdata = req.value_elem;
    end
  end

  sltc_table #(.AW(AW)) u_table (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .a_addr ({a_row[IW-1:0], a_col[IW-1:0]}),
    .b_addr ({b_row[IW-1:0], b_col[IW-1:0]}),
    .a_q    (a_q),
    .b_q    (b_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept && (req.req_type == REQ_CHECK) && (n_eff != '0)) state_nxt = ST_AXY;
      ST_AXY:   state_nxt = ST_AXYW;
      ST_AXYW:  state_nxt = ST_AZ0;
      ST_AZ0:   state_nxt = ST_AZ1;
      ST_AZ1: begin
        if (!last_z)      state_nxt = ST_AZ0;
        else if (last_y && last_x) state_nxt = ST_CMP;
        else              state_nxt = ST_AXY;
      end
      ST_CMP:   if (last_x && last_y) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign comm_fin = comm_r && (a_data == b_data);
  assign idem_fin = idem_r && !(diag_r && (a_data != xd_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_cnt_r  <= '0;
      cmp_pend_r <= 1'b0;
      cpend_r    <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cmp_pend_r <= (state_r == ST_AZ1);
      cpend_r    <= (state_r == ST_CMP);
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      ov_r <= (accept && !((req.req_type == REQ_CHECK) && (n_eff != '0))) ||
              (state_r == ST_FIN);
    end
  end

  always_ff @(posedge clk) begin
    a_hit_r   <= a_hit;
    b_hit_r   <= b_hit;
    a_const_r <= a_const;
    b_const_r <= b_const;
    diag_r    <= (x_r == y_r);
    xd_r      <= x_r[ELEM_W-1:0];

    if (cmp_pend_r && (a_data != right_r)) assoc_r <= 1'b0;
    if (cpend_r) begin
      comm_r <= comm_fin;
      idem_r <= idem_fin;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          n_r     <= n_eff;
          x_r     <= '0;
          y_r     <= '0;
          z_r     <= '0;
          assoc_r <= 1'b1;
          comm_r  <= 1'b1;
          idem_r  <= 1'b1;
          bad_r   <= req_bad;
          rq_r    <= (req.req_type == REQ_QUERY) && !req_bad;
          fa_r    <= (req.req_type == REQ_CHECK);
          fc_r    <= (req.req_type == REQ_CHECK);
          fi_r    <= (req.req_type == REQ_CHECK);
          fv_r    <= (req.req_type == REQ_CHECK);
        end
      end
      ST_AXYW: xy_r <= a_data;
      ST_AZ1: begin
        right_r <= b_data;
        if (!last_z) begin
          z_r <= z_r + COUNT_W'(1);
        end else begin
          z_r <= '0;
          if (!last_y) begin
            y_r <= y_r + COUNT_W'(1);
          end else begin
            y_r <= '0;
            if (!last_x) x_r <= x_r + COUNT_W'(1);
            else         x_r <= '0;
          end
        end
      end
      ST_CMP: begin
        if (!last_y) begin
          y_r <= y_r + COUNT_W'(1);
        end else begin
          y_r <= '0;
          x_r <= x_r + COUNT_W'(1);
        end
      end
      ST_FIN: begin
        rq_r <= 1'b0;
        fa_r <= assoc_r;
        fc_r <= comm_fin;
        fi_r <= idem_fin;
        fv_r <= assoc_r && comm_fin && idem_fin;
      end
      default: ;
    endcase
  end

  assign out_valid       = ov_r;
  assign res.read_value  = rq_r ? a_data : '0;
  assign res.bad_element = bad_r;
  assign res.assoc_ok    = fa_r;
  assign res.comm_ok     = fc_r;
  assign res.idem_ok     = fi_r;
  assign res.valid_ok    = fv_r;

endmodule

>>> rtl/core/semilattice_table_checker.sv
// channel  ports                                     handshake
// in       in_req_type/row/col/value_elem            start & !busy
// out      out_read_value, out_bad_element, *_ok     out_valid, one cycle, no stall
// cfg      cfg_element_count                         cfg_valid & cfg_ready
//
// Write, query and unused request types: result strobe one cycle after the request,
// and the next request is taken in that same cycle.
// Check with n elements: the result follows the triple walk over the two read ports of the
// table memory; count 0 answers in the cycle after the request.
// Reset: a clearing pass over all (2^clog2(min(MAX_ELEMS,16)))^2 table entries (256 by default)
// loads the diagonal; busy stays high meanwhile, configuration writes are still taken.
// The result side cannot stall; cfg_ready is always high.
module semilattice_table_checker #(
  parameter int MAX_ELEMS = sltc_pkg::DEF_MAX_ELEMS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [sltc_pkg::REQ_W-1:0]   in_req_type,
  input  logic [sltc_pkg::ELEM_W-1:0]  in_row_elem,
  input  logic [sltc_pkg::ELEM_W-1:0]  in_col_elem,
  input  logic [sltc_pkg::ELEM_W-1:0]  in_value_elem,
  output logic                         out_valid,
  output logic [sltc_pkg::ELEM_W-1:0]  out_read_value,
  output logic                         out_bad_element,
  output logic                         out_assoc_ok,
  output logic                         out_comm_ok,
  output logic                         out_idem_ok,
  output logic                         out_valid_ok,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sltc_pkg::COUNT_W-1:0] cfg_element_count
);
  import sltc_pkg::*;

  logic [COUNT_W-1:0] element_count_r;
  logic [COUNT_W-1:0] n_eff;
  req_t               req;
  result_t            res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      element_count_r <= cfg_element_count;
    end
  end

  // counts above the table size saturate
  always_comb begin
    if (int'(element_count_r) > MAX_ELEMS) n_eff = COUNT_W'(MAX_ELEMS);
    else                                   n_eff = element_count_r;
  end

  assign req.req_type   = in_req_type;
  assign req.row_elem   = in_row_elem;
  assign req.col_elem   = in_col_elem;
  assign req.value_elem = in_value_elem;

  sltc_engine #(.MAX_ELEMS(MAX_ELEMS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .n_eff     (n_eff),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_read_value  = res.read_value;
  assign out_bad_element = res.bad_element;
  assign out_assoc_ok    = res.assoc_ok;
  assign out_comm_ok     = res.comm_ok;
  assign out_idem_ok     = res.idem_ok;
  assign out_valid_ok    = res.valid_ok;

endmodule

>>> rtl/core/sltc_checker.sv
module sltc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [sltc_pkg::REQ_W-1:0]  in_req_type,
  input logic                        out_valid,
  input logic [sltc_pkg::ELEM_W-1:0] out_read_value,
  input logic                        out_bad_element,
  input logic                        out_assoc_ok,
  input logic                        out_comm_ok,
  input logic                        out_idem_ok,
  input logic                        out_valid_ok
);
  import sltc_pkg::*;

  // reset always starts the clearing pass
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // write, query and unused-type requests answer in the next cycle
  a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type != REQ_CHECK)) |=> out_valid)
    else $error("missing result after write or query");

  a_valid_is_and: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_ok == (out_assoc_ok && out_comm_ok && out_idem_ok)))
    else $error("valid_ok differs from the three properties");

  a_bad_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_element) |->
      ((out_read_value == '0) && !out_assoc_ok && !out_comm_ok && !out_idem_ok))
    else $error("bad request result carries data");

endmodule

bind semilattice_table_checker sltc_checker u_sltc_checker (.*);
